// ===== sv/pff_pkg.sv =====
// Shared types, constants and helper functions of the particle free-flight update block.
package pff_pkg;

  // Field widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned VEL_W  = 32;
  localparam int unsigned CELL_W = 8;
  localparam int unsigned CPS_W  = 9;

  // Upper bound on cells per axis, then limited by the reach of the cell field
  localparam int unsigned MAX_CELLS_PER_SIDE = 256;
  localparam int unsigned CELL_REACH = 1 << CELL_W;
  localparam int unsigned CELL_LIMIT = (MAX_CELLS_PER_SIDE < CELL_REACH) ?
                                       MAX_CELLS_PER_SIDE : CELL_REACH;

  // Register reset values
  localparam logic [31:0]      TIME_STEP_RST  = 32'd4295;
  localparam logic [31:0]      CUBE_LEN_RST   = 32'd314572800;
  localparam logic [31:0]      INV_CELL_RST   = 32'd32768;
  localparam logic [CPS_W-1:0] CPS_RST        = 9'd150;
  localparam logic             Z_WRAPS_RST    = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_CUBE_LEN  = 3'd1,
    REG_INV_CELL  = 3'd2,
    REG_CPS       = 3'd3,
    REG_Z_WRAPS   = 3'd4
  } cfg_reg_e;

  // Configuration bundle handed to the datapath
  typedef struct packed {
    logic [31:0]      time_step;
    logic [31:0]      cube_length;
    logic [31:0]      inv_cell_len;
    logic [CPS_W-1:0] cells_per_side;
    logic             z_wraps;
  } cfg_t;

  // Negate a velocity, most negative value saturates to the largest positive
  function automatic logic [VEL_W-1:0] neg_vel(input logic [VEL_W-1:0] v);
    logic [VEL_W-1:0] r;
    if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r = (~v) + VEL_W'(1);
    end
    return r;
  endfunction

  // Largest legal cell index for a given cells-per-side setting
  function automatic logic [CELL_W-1:0] cell_max(input logic [CPS_W-1:0] cps);
    logic [CPS_W:0] n;
    logic [CPS_W:0] lim;
    lim = (CPS_W+1)'(CELL_LIMIT);
    if (cps == '0) begin
      n = (CPS_W+1)'(1);
    end else if ({1'b0, cps} > lim) begin
      n = lim;
    end else begin
      n = {1'b0, cps};
    end
    n = n - (CPS_W+1)'(1);
    return n[CELL_W-1:0];
  endfunction

endpackage

// ===== sv/pff_move.sv =====
// One axis of the move: velocity times dt, position update, wall reflection or wrap.
module pff_move
  import pff_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             wrap_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic [VEL_W-1:0] vel_i,
  output logic [POS_W-1:0] pos_o,
  output logic [VEL_W-1:0] vel_o
);

  // Stage 1: signed velocity times unsigned dt
  logic signed [64:0] prod;
  logic [63:0]        prod_q;
  logic [POS_W-1:0]   pos1_q;
  logic [VEL_W-1:0]   vel1_q;

  assign prod = $signed(vel_i) * $signed({1'b0, cfg_i.time_step});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod[63:0];
      pos1_q <= pos_i;
      vel1_q <= vel_i;
    end
  end

  // Stage 2: add floor(prod / 2^32) and classify against the walls
  logic [31:0] disp;
  logic [33:0] p_d;
  logic [32:0] len;
  logic        neg_d;
  logic        hi_d;
  logic [33:0] p2_q;
  logic        neg2_q;
  logic        hi2_q;
  logic [VEL_W-1:0] vel2_q;

  assign len   = (cfg_i.cube_length == '0) ? 33'd1 : {1'b0, cfg_i.cube_length};
  assign disp  = prod_q[63:32];
  assign p_d   = {2'b00, pos1_q} + {{2{disp[31]}}, disp};
  assign neg_d = p_d[33];
  assign hi_d  = !p_d[33] && (p_d >= {1'b0, len});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q   <= p_d;
      neg2_q <= neg_d;
      hi2_q  <= hi_d;
      vel2_q <= vel1_q;
    end
  end

  // Stage 3: mirror or wrap once, then saturate to the position range
  logic [34:0]      pe;
  logic [34:0]      lene;
  logic [34:0]      r;
  logic [POS_W-1:0] pos_d;
  logic [VEL_W-1:0] vel_d;

  assign pe   = {p2_q[33], p2_q};
  assign lene = {2'b00, len};

  always_comb begin
    r     = pe;
    vel_d = vel2_q;
    if (wrap_i) begin
      if (neg2_q) begin
        r = pe + lene;
      end else if (hi2_q) begin
        r = pe - lene;
      end
    end else begin
      if (neg2_q) begin
        r     = (~pe) + 35'd1;
        vel_d = neg_vel(vel2_q);
      end else if (hi2_q) begin
        r     = {lene[33:0], 1'b0} - pe;
        vel_d = neg_vel(vel2_q);
      end
    end
    if (r[34]) begin
      pos_d = '0;
    end else if (r[33:32] != 2'b00) begin
      pos_d = '1;
    end else begin
      pos_d = r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_o <= pos_d;
      vel_o <= vel_d;
    end
  end

endmodule

// ===== sv/pff_cell.sv =====
// Cell index of one axis: position times inverse cell length, truncated and clamped.
module pff_cell
  import pff_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [VEL_W-1:0]  vel_i,
  output logic [POS_W-1:0]  pos_o,
  output logic [VEL_W-1:0]  vel_o,
  output logic [CELL_W-1:0] cell_o
);

  // Stage 4: unsigned Q12.20 times Q16.16 gives Q28.36
  logic [63:0]      prod_q;
  logic [POS_W-1:0] pos4_q;
  logic [VEL_W-1:0] vel4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(pos_i) * 64'(cfg_i.inv_cell_len);
      pos4_q <= pos_i;
      vel4_q <= vel_i;
    end
  end

  // Stage 5: integer part, clamped to the last cell
  logic [27:0]       cidx;
  logic [CELL_W-1:0] lim;
  logic [CELL_W-1:0] cell_d;

  assign cidx   = prod_q[63:36];
  assign lim    = cell_max(cfg_i.cells_per_side);
  assign cell_d = (cidx > 28'(lim)) ? lim : cidx[CELL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_o  <= pos4_q;
      vel_o  <= vel4_q;
      cell_o <= cell_d;
    end
  end

endmodule

// ===== sv/particle_free_flight_update_top.sv =====
// Top level of the particle free-flight update: config registers, stream control, three axes.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        pos_x,pos_y,pos_z,vel_x,vel_y,vel_z
//  m_axis    out  m_axis_tvalid/tready        new_pos_x..z, new_vel_x..z, cell_x..z
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_addr_i register index, cfg_data_i
//
// Five register stages: multiply, add and wall test, reflect/wrap, cell multiply, clamp.
// One beat per cycle is sustained while m_axis keeps taking output beats.
// All stages advance together whenever the output register is empty or being taken;
// a stall at m_axis freezes every stage, nothing is dropped or repeated.
// Reset clears the stage valid bits and restores the config registers; cfg is always ready.
module particle_free_flight_update_top
  import pff_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], vel_x[127:96], vel_y[159:128], vel_z[191:160]
  input  logic [191:0] s_axis_tdata,
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_pos_x[31:0], new_pos_y[63:32], new_pos_z[95:64], new_vel_x[127:96],
  // new_vel_y[159:128], new_vel_z[191:160], cell_x[199:192], cell_y[207:200],
  // cell_z[215:208]
  output logic [215:0] m_axis_tdata,
  // config writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned STAGES = 5;

  // Config registers
  cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step      <= TIME_STEP_RST;
      cfg_q.cube_length    <= CUBE_LEN_RST;
      cfg_q.inv_cell_len   <= INV_CELL_RST;
      cfg_q.cells_per_side <= CPS_RST;
      cfg_q.z_wraps        <= Z_WRAPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_TIME_STEP: cfg_q.time_step      <= cfg_data_i;
        REG_CUBE_LEN:  cfg_q.cube_length    <= cfg_data_i;
        REG_INV_CELL:  cfg_q.inv_cell_len   <= cfg_data_i;
        REG_CPS:       cfg_q.cells_per_side <= cfg_data_i[CPS_W-1:0];
        REG_Z_WRAPS:   cfg_q.z_wraps        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and stage valid bits
  logic              en;
  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;

  assign en            = !valid_q[STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[STAGES-1];
  assign valid_d       = {valid_q[STAGES-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Three axes: move, then cell index
  logic [POS_W-1:0]  mpos [3];
  logic [VEL_W-1:0]  mvel [3];
  logic [POS_W-1:0]  opos [3];
  logic [VEL_W-1:0]  ovel [3];
  logic [CELL_W-1:0] ocell [3];
  logic [2:0]        wrap;

  assign wrap = {cfg_q.z_wraps, 2'b00};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pff_move u_move (
      .clk_i  (clk_i),
      .en_i   (en),
      .cfg_i  (cfg_q),
      .wrap_i (wrap[a]),
      .pos_i  (s_axis_tdata[32*a +: 32]),
      .vel_i  (s_axis_tdata[96 + 32*a +: 32]),
      .pos_o  (mpos[a]),
      .vel_o  (mvel[a])
    );

    pff_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cfg_i  (cfg_q),
      .pos_i  (mpos[a]),
      .vel_i  (mvel[a]),
      .pos_o  (opos[a]),
      .vel_o  (ovel[a]),
      .cell_o (ocell[a])
    );

    assign m_axis_tdata[32*a +: 32]      = opos[a];
    assign m_axis_tdata[96 + 32*a +: 32] = ovel[a];
    assign m_axis_tdata[192 + 8*a +: 8]  = ocell[a];
  end

  // Checks on the stage control and the clamp
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while output register is empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted beat did not enter first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("stage valid bits moved during a stall");

  a_cell_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ocell[0] <= cell_max(cfg_q.cells_per_side)) &&
                      (ocell[1] <= cell_max(cfg_q.cells_per_side)) &&
                      (ocell[2] <= cell_max(cfg_q.cells_per_side)))
    else $error("cell index above configured limit");

endmodule
